// File: hw/rtl/salc_pkg.sv
`timescale 1ns / 1ps

package salc_pkg;

	localparam int ADDR_W     = 64;
	localparam int TAG_W      = 64;
	localparam int STAMP_W    = 64;
	localparam int TOTAL_W    = 32;
	localparam int IDX_W      = 7;
	localparam int WAY_IDX_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic                 found;
		logic                 hit;
		logic [WAY_IDX_W-1:0] way;
	} scan_t;

	typedef struct packed {
		logic [1:0] hits;
		logic       miss;
		logic       evict;
	} delta_t;

endpackage

// File: hw/rtl/salc_ifs.sv
`timescale 1ns / 1ps

interface salc_in_if;
	logic                        valid;
	logic                        ready;
	logic [salc_pkg::ADDR_W-1:0] address;
	logic                        operation;

	modport source (output valid, address, operation, input ready);
	modport sink (input valid, address, operation, output ready);
endinterface

interface salc_out_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   hits_added;
	logic                         was_miss;
	logic                         was_evict;
	logic [salc_pkg::TOTAL_W-1:0] total_hit_count;
	logic [salc_pkg::TOTAL_W-1:0] total_miss_count;
	logic [salc_pkg::TOTAL_W-1:0] total_evict_count;

	modport source (output valid, hits_added, was_miss, was_evict, total_hit_count,
		total_miss_count, total_evict_count, input ready);
	modport sink (input valid, hits_added, was_miss, was_evict, total_hit_count,
		total_miss_count, total_evict_count, output ready);
endinterface

interface salc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [salc_pkg::CFG_IDX_W-1:0]  index;
	logic [salc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/salc_scan.sv
`timescale 1ns / 1ps

module salc_scan (
	input  logic                           clk,
	input  logic                           step,
	input  logic                           first,
	input  logic [salc_pkg::WAY_IDX_W-1:0] way,
	input  logic                           line_valid,
	input  logic [salc_pkg::TAG_W-1:0]     line_tag,
	input  logic [salc_pkg::STAMP_W-1:0]   line_stamp,
	input  logic [salc_pkg::TAG_W-1:0]     ref_tag,
	output salc_pkg::scan_t                res
);

	logic [salc_pkg::STAMP_W-1:0]   least_q;
	logic [salc_pkg::WAY_IDX_W-1:0] min_way_q;
	logic                           is_hit;
	logic                           lower;

	assign is_hit = line_valid && (line_tag == ref_tag);
	// strict compare keeps the lowest way on a tie
	assign lower  = first || (line_stamp < least_q);

	always_comb begin
		res.found = !line_valid || is_hit;
		res.hit   = is_hit;
		res.way   = (res.found || lower) ? way : min_way_q;
	end

	always_ff @(posedge clk) begin
		if (step && lower) begin
			least_q   <= line_stamp;
			min_way_q <= way;
		end
	end

endmodule

// File: hw/rtl/salc_result.sv
`timescale 1ns / 1ps

module salc_result (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              update,
	input  salc_pkg::delta_t  delta,
	output logic              free,
	salc_out_if.source        out
);

	logic [salc_pkg::TOTAL_W-1:0] hit_q;
	logic [salc_pkg::TOTAL_W-1:0] miss_q;
	logic [salc_pkg::TOTAL_W-1:0] evict_q;
	logic                         valid_q;
	logic [1:0]                   hits_q;
	logic                         was_miss_q;
	logic                         was_evict_q;
	logic [salc_pkg::TOTAL_W:0]   hit_sum;
	logic [salc_pkg::TOTAL_W:0]   miss_sum;
	logic [salc_pkg::TOTAL_W:0]   evict_sum;
	logic [salc_pkg::TOTAL_W-1:0] hit_n;
	logic [salc_pkg::TOTAL_W-1:0] miss_n;
	logic [salc_pkg::TOTAL_W-1:0] evict_n;

	assign free = !valid_q || out.ready;

	assign hit_sum   = {1'b0, hit_q} + {{(salc_pkg::TOTAL_W - 1){1'b0}}, delta.hits};
	assign miss_sum  = {1'b0, miss_q} + {{salc_pkg::TOTAL_W{1'b0}}, delta.miss};
	assign evict_sum = {1'b0, evict_q} + {{salc_pkg::TOTAL_W{1'b0}}, delta.evict};

	// saturate on carry out
	assign hit_n   = hit_sum[salc_pkg::TOTAL_W] ? '1 : hit_sum[salc_pkg::TOTAL_W-1:0];
	assign miss_n  = miss_sum[salc_pkg::TOTAL_W] ? '1 : miss_sum[salc_pkg::TOTAL_W-1:0];
	assign evict_n = evict_sum[salc_pkg::TOTAL_W] ? '1 : evict_sum[salc_pkg::TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= '0;
			miss_q  <= '0;
			evict_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (update) begin
				hit_q   <= hit_n;
				miss_q  <= miss_n;
				evict_q <= evict_n;
				valid_q <= 1'b1;
			end else if (out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			hits_q      <= delta.hits;
			was_miss_q  <= delta.miss;
			was_evict_q <= delta.evict;
		end
	end

	assign out.valid             = valid_q;
	assign out.hits_added        = hits_q;
	assign out.was_miss          = was_miss_q;
	assign out.was_evict         = was_evict_q;
	assign out.total_hit_count   = hit_q;
	assign out.total_miss_count  = miss_q;
	assign out.total_evict_count = evict_q;

endmodule

// File: hw/rtl/set_assoc_lru_cache_sim_core.sv
`timescale 1ns / 1ps
// Each accepted item is scanned one way at a time, up to the first invalid or matching line
// or through all ways in use; the scan reads one line per cycle from the line memory and
// compares it in the shared scan unit. The result is registered when the item is written
// back, which waits until the output is free, and no new item is accepted before then.
// Reset: totals clear at once; a clearing pass then zeroes valid bits and set stamps, and no
// item is accepted until it ends. Configuration writes are taken at any time.

module set_assoc_lru_cache_sim_core #(
	parameter int SETS = 64,
	parameter int WAYS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	salc_in_if.sink    in,
	salc_out_if.source out,
	salc_cfg_if.sink   cfg
);

	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCNT_W = $clog2(WAYS + 1);
	localparam int LINES  = SETS << WAY_W;
	localparam int DIV_SH = salc_pkg::IDX_W + $clog2(SETS);
	localparam int DIV_M  = ((1 << DIV_SH) + SETS - 1) / SETS;

	salc_pkg::state_t state_q, state_n;

	logic [2:0]                    set_bits_q;
	logic [5:0]                    block_bits_q;
	logic [3:0]                    ways_q;
	logic [SET_W-1:0]              clr_q;
	logic [salc_pkg::TAG_W-1:0]    tag_q;
	logic [salc_pkg::IDX_W-1:0]    idx_q;
	logic                          op_q;
	logic [SET_W-1:0]              set_q;
	logic [WAY_W-1:0]              way_q;
	logic [WAY_W-1:0]              victim_q;
	logic                          hit_q;
	logic                          evict_q;

	logic [WAYS-1:0]               row_vld_mem [0:SETS-1];
	logic [salc_pkg::STAMP_W-1:0]  row_stamp_mem [0:SETS-1];
	logic [WAYS-1:0]               row_valid_q;
	logic [salc_pkg::STAMP_W-1:0]  row_stamp_q;
	logic [salc_pkg::TAG_W-1:0]    line_tag_mem [0:LINES-1];
	logic [salc_pkg::STAMP_W-1:0]  line_stamp_mem [0:LINES-1];
	logic [salc_pkg::TAG_W-1:0]    line_tag_q;
	logic [salc_pkg::STAMP_W-1:0]  line_stamp_q;

	logic                          in_acc;
	logic [6:0]                    low_c;
	logic [salc_pkg::TAG_W-1:0]    tag_c;
	logic [salc_pkg::ADDR_W-1:0]   shifted_c;
	logic [salc_pkg::IDX_W-1:0]    idx_c;
	logic [SET_W-1:0]              set_c;
	logic [WCNT_W-1:0]             ways_eff;
	logic                          last_way;
	logic                          scan_step;
	logic                          out_free;
	logic                          commit;
	logic                          row_we;
	logic [SET_W-1:0]              row_waddr;
	logic [WAYS-1:0]               row_vld_wdata;
	logic [salc_pkg::STAMP_W-1:0]  row_stamp_wdata;
	logic [SET_W+WAY_W-1:0]        line_raddr;
	logic [SET_W+WAY_W-1:0]        line_waddr;
	salc_pkg::scan_t               scan_res;
	salc_pkg::delta_t              delta;

	// set index modulo SETS: reciprocal multiply gives the quotient, exact for any index
	// below 2**IDX_W; subtract quotient times SETS for the remainder
	function automatic logic [SET_W-1:0] set_of(input logic [salc_pkg::IDX_W-1:0] idx);
		logic [31:0] quo;
		logic [31:0] rem;
		quo = (32'(idx) * 32'(DIV_M)) >> DIV_SH;
		rem = 32'(idx) - quo * 32'(SETS);
		return rem[SET_W-1:0];
	endfunction

	assign in_acc    = in.valid && in.ready;
	assign cfg.ready = 1'b1;

	// tag and set index of the incoming item
	assign low_c     = {4'd0, set_bits_q} + {1'b0, block_bits_q};
	assign tag_c     = (low_c >= 7'd64) ? '0 : (in.address & ('1 << low_c[5:0]));
	assign shifted_c = in.address >> block_bits_q;
	assign idx_c     = shifted_c[salc_pkg::IDX_W-1:0] & ~(7'h7F << set_bits_q);
	assign set_c     = set_of(idx_q);

	always_comb begin
		if (ways_q == 4'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (32'(ways_q) > WAYS) begin
			ways_eff = WCNT_W'(WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_q);
		end
	end

	assign last_way = (32'(way_q) + 32'd1) == 32'(ways_eff);
	assign commit   = (state_q == salc_pkg::ST_WRITE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_q       <= 4'd1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				salc_pkg::CFG_SET_BITS:   set_bits_q   <= cfg.data[2:0];
				salc_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg.data[5:0];
				salc_pkg::CFG_WAYS_USED:  ways_q       <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			salc_pkg::ST_CLEAR: begin
				if (clr_q == SET_W'(SETS - 1)) state_n = salc_pkg::ST_IDLE;
			end
			salc_pkg::ST_IDLE: begin
				if (in_acc) state_n = salc_pkg::ST_READ;
			end
			salc_pkg::ST_READ: state_n = salc_pkg::ST_SCAN;
			salc_pkg::ST_SCAN: begin
				if (scan_res.found || last_way) state_n = salc_pkg::ST_WRITE;
			end
			salc_pkg::ST_WRITE: begin
				if (out_free) state_n = salc_pkg::ST_IDLE;
			end
			default: state_n = salc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in.ready  = 1'b0;
		scan_step = 1'b0;
		row_we    = 1'b0;
		row_waddr = set_q;
		row_vld_wdata   = row_valid_q | (WAYS'(1) << victim_q);
		row_stamp_wdata = row_stamp_q + 64'd1;
		line_raddr = {set_q, WAY_W'(way_q + 1'b1)};
		unique case (state_q)
			salc_pkg::ST_CLEAR: begin
				row_we          = 1'b1;
				row_waddr       = clr_q;
				row_vld_wdata   = '0;
				row_stamp_wdata = '0;
			end
			salc_pkg::ST_IDLE:  in.ready = 1'b1;
			salc_pkg::ST_READ:  line_raddr = {set_c, WAY_W'(0)};
			salc_pkg::ST_SCAN:  scan_step = 1'b1;
			salc_pkg::ST_WRITE: row_we = out_free;
			default: ;
		endcase
	end

	assign line_waddr = {set_q, victim_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == salc_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_q <= tag_c;
			idx_q <= idx_c;
			op_q  <= in.operation;
		end
		if (state_q == salc_pkg::ST_READ) begin
			set_q <= set_c;
			way_q <= '0;
		end
		if (scan_step) begin
			if (scan_res.found || last_way) begin
				victim_q <= scan_res.way[WAY_W-1:0];
				hit_q    <= scan_res.hit;
				evict_q  <= !scan_res.found;
			end else begin
				way_q <= way_q + 1'b1;
			end
		end
	end

	// per-set row: valid bits and set stamp
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_vld_mem[row_waddr]   <= row_vld_wdata;
			row_stamp_mem[row_waddr] <= row_stamp_wdata;
		end
		row_valid_q <= row_vld_mem[set_c];
		row_stamp_q <= row_stamp_mem[set_c];
	end

	// line store: tag and stamp of each way
	always_ff @(posedge clk) begin
		if (commit) begin
			line_tag_mem[line_waddr]   <= tag_q;
			line_stamp_mem[line_waddr] <= row_stamp_q;
		end
		line_tag_q   <= line_tag_mem[line_raddr];
		line_stamp_q <= line_stamp_mem[line_raddr];
	end

	salc_scan u_scan (
		.clk        (clk),
		.step       (scan_step),
		.first      (way_q == '0),
		.way        (salc_pkg::WAY_IDX_W'(way_q)),
		.line_valid (row_valid_q[way_q]),
		.line_tag   (line_tag_q),
		.line_stamp (line_stamp_q),
		.ref_tag    (tag_q),
		.res        (scan_res)
	);

	// a modify adds one hit on top of the outcome
	assign delta.hits  = {hit_q & op_q, hit_q ^ op_q};
	assign delta.miss  = !hit_q;
	assign delta.evict = evict_q;

	salc_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.update (commit),
		.delta  (delta),
		.free   (out_free),
		.out    (out)
	);

endmodule
